### hdl/pfs_pkg.sv
// Shared constants, codes and types of the page frame free stack.
`default_nettype none
package pfs_pkg;

    // Sizing of the allocator.
    localparam int PAGE_CAPACITY = 65536;
    localparam int PAGE_BYTES    = 4096;
    localparam int ADDRESS_BITS  = 34;

    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
    localparam int FRAME_W    = ADDRESS_BITS - PAGE_SHIFT;
    localparam int IDX_W      = (PAGE_CAPACITY > 1) ? $clog2(PAGE_CAPACITY) : 1;
    localparam int DEPTH_W    = $clog2(PAGE_CAPACITY + 1);

    // Configuration registers.
    localparam int KEND_W    = 34;
    localparam int MTOP_W    = 35;
    localparam int CFG_W     = 35;
    localparam int CFG_IDX_W = 1;
    localparam int TOPF_W    = MTOP_W - PAGE_SHIFT;

    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_END = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MEMORY_TOP = 1'd1;

    localparam logic [KEND_W-1:0] KERNEL_END_RST = 34'h0_8000_0000;
    localparam logic [MTOP_W-1:0] MEMORY_TOP_RST = 35'h0_8800_0000;

    // Stream widths.
    localparam int ACT_W       = 2;
    localparam int STAT_W      = 2;
    localparam int IN_TDATA_W  = ((ADDRESS_BITS + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((ADDRESS_BITS + DEPTH_W + 7) / 8) * 8;

    // Request actions.
    localparam logic [ACT_W-1:0] ACT_FREE  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_ALLOC = 2'd1;
    localparam logic [ACT_W-1:0] ACT_INIT  = 2'd2;

    // Result status codes.
    localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STAT_W-1:0] STAT_BAD_FREE = 2'd1;
    localparam logic [STAT_W-1:0] STAT_EMPTY    = 2'd2;
    localparam logic [STAT_W-1:0] STAT_FULL     = 2'd3;

    // Classified operations handed from the front end to the back end.
    localparam int OP_W = 3;
    localparam logic [OP_W-1:0] OP_FREE     = 3'd0;
    localparam logic [OP_W-1:0] OP_FREE_BAD = 3'd1;
    localparam logic [OP_W-1:0] OP_ALLOC    = 3'd2;
    localparam logic [OP_W-1:0] OP_INIT     = 3'd3;
    localparam logic [OP_W-1:0] OP_NOP      = 3'd4;

    typedef struct packed {
        logic [OP_W-1:0]    kind;
        logic [FRAME_W-1:0] frame;
    } op_t;

    typedef struct packed {
        logic               grant;
        logic [STAT_W-1:0]  status;
        logic [DEPTH_W-1:0] free_pages;
    } res_t;

endpackage
`default_nettype wire

### hdl/pfs_front.sv
// Front end: takes request beats and classifies them into operations.
`default_nettype none
module pfs_front
    import pfs_pkg::*;
(
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [IN_TDATA_W-1:0] s_tdata,
    input  wire logic [ACT_W-1:0]      s_tuser,
    input  wire logic [KEND_W-1:0]     kernel_end,
    input  wire logic [MTOP_W-1:0]     memory_top,
    output logic                       push_valid,
    input  wire logic                  push_ready,
    output op_t                        push_op
);

    logic [ADDRESS_BITS-1:0] addr;
    logic                    bad_free;

    assign addr = s_tdata[ADDRESS_BITS-1:0];

    // A freed page must be aligned and lie inside [kernel_end, memory_top).
    assign bad_free = (addr[PAGE_SHIFT-1:0] != '0)
                   || (KEND_W'(addr) < kernel_end)
                   || (MTOP_W'(addr) >= memory_top);

    always_comb
    begin
        push_op.frame = addr[ADDRESS_BITS-1:PAGE_SHIFT];
        unique case (s_tuser)
            ACT_FREE:  push_op.kind = bad_free ? OP_FREE_BAD : OP_FREE;
            ACT_ALLOC: push_op.kind = OP_ALLOC;
            ACT_INIT:  push_op.kind = OP_INIT;
            default:   push_op.kind = OP_NOP;
        endcase
    end

    assign push_valid = s_tvalid;
    assign s_tready   = push_ready;

endmodule
`default_nettype wire

### hdl/pfs_queue.sv
// Two-entry queue of classified operations between front and back end.
`default_nettype none
module pfs_queue
    import pfs_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push_valid,
    output logic      push_ready,
    input  wire op_t  push_op,
    output logic      pop_valid,
    input  wire logic pop_ready,
    output op_t       pop_op
);

    op_t        slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push, do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_op     = slot_reg[rd_ptr_reg];

    assign do_push = push_valid && push_ready;
    assign do_pop  = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule
`default_nettype wire

### hdl/pfs_back.sv
// Back end: frame stack memory, push/pop/fill execution and result register.
`default_nettype none
module pfs_back
    import pfs_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic [KEND_W-1:0]      kernel_end,
    input  wire logic [MTOP_W-1:0]      memory_top,
    input  wire logic                   op_valid,
    output logic                        op_ready,
    input  wire op_t                    op,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [OUT_TDATA_W-1:0]      m_tdata,
    output logic [STAT_W-1:0]           m_tuser
);

    localparam logic BK_RUN  = 1'b0;
    localparam logic BK_FILL = 1'b1;

    logic [FRAME_W-1:0] stack_mem [PAGE_CAPACITY];

    logic               state_reg, state_next;
    logic [DEPTH_W-1:0] depth_reg, depth_next;
    logic               r2_valid_reg, r2_valid_next;
    res_t               r2_res_reg, r2_res_next;
    logic               out_valid_reg, out_valid_next;
    logic [ADDRESS_BITS-1:0] out_grant_reg, out_grant_next;
    logic [STAT_W-1:0]  out_status_reg, out_status_next;
    logic [DEPTH_W-1:0] out_free_reg, out_free_next;
    logic [FRAME_W-1:0] rd_data_reg;
    logic [DEPTH_W-1:0] fill_idx_reg, fill_idx_next;
    logic [FRAME_W-1:0] fill_frame_reg, fill_frame_next;
    logic [DEPTH_W-1:0] fill_cnt_reg, fill_cnt_next;

    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic [FRAME_W-1:0] wr_data;
    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;
    logic [DEPTH_W-1:0] depth_dec;

    logic               out_ready, r2_adv, issue;
    res_t               res;

    logic [MTOP_W-1:0]  kend_round;
    logic [TOPF_W-1:0]  start_frame, top_frame, span;
    logic               has_pages, over;
    logic [DEPTH_W-1:0] init_count;

    // Range covered by an init: whole pages from rounded-up kernel_end to memory_top.
    assign kend_round  = MTOP_W'(kernel_end) + MTOP_W'(PAGE_BYTES - 1);
    assign start_frame = kend_round[MTOP_W-1:PAGE_SHIFT];
    assign top_frame   = memory_top[MTOP_W-1:PAGE_SHIFT];
    assign span        = top_frame - start_frame;
    assign has_pages   = start_frame < top_frame;
    assign over        = has_pages && (span > TOPF_W'(PAGE_CAPACITY));
    assign init_count  = !has_pages ? '0 : (over ? DEPTH_W'(PAGE_CAPACITY) : DEPTH_W'(span));

    assign out_ready = !out_valid_reg || m_tready;
    assign r2_adv    = r2_valid_reg && out_ready;
    assign op_ready  = (state_reg == BK_RUN) && (!r2_valid_reg || out_ready);
    assign issue     = op_valid && op_ready;
    assign depth_dec = depth_reg - DEPTH_W'(1);

    always_comb
    begin
        state_next      = state_reg;
        depth_next      = depth_reg;
        fill_idx_next   = fill_idx_reg;
        fill_frame_next = fill_frame_reg;
        fill_cnt_next   = fill_cnt_reg;
        wr_en           = 1'b0;
        wr_addr         = depth_reg[IDX_W-1:0];
        wr_data         = op.frame;
        rd_en           = 1'b0;
        rd_addr         = depth_dec[IDX_W-1:0];
        res.grant       = 1'b0;
        res.status      = STAT_OK;
        res.free_pages  = depth_reg;

        if (state_reg == BK_FILL)
        begin
            wr_en           = 1'b1;
            wr_addr         = fill_idx_reg[IDX_W-1:0];
            wr_data         = fill_frame_reg;
            fill_idx_next   = fill_idx_reg + DEPTH_W'(1);
            fill_frame_next = fill_frame_reg + FRAME_W'(1);
            if (fill_idx_next == fill_cnt_reg)
            begin
                state_next = BK_RUN;
            end
        end
        else if (issue)
        begin
            unique case (op.kind)
                OP_FREE:
                begin
                    if (depth_reg == DEPTH_W'(PAGE_CAPACITY))
                    begin
                        res.status = STAT_FULL;
                    end
                    else
                    begin
                        wr_en          = 1'b1;
                        depth_next     = depth_reg + DEPTH_W'(1);
                        res.free_pages = depth_next;
                    end
                end
                OP_FREE_BAD:
                begin
                    res.status = STAT_BAD_FREE;
                end
                OP_ALLOC:
                begin
                    if (depth_reg == '0)
                    begin
                        res.status = STAT_EMPTY;
                    end
                    else
                    begin
                        rd_en          = 1'b1;
                        depth_next     = depth_dec;
                        res.grant      = 1'b1;
                        res.free_pages = depth_dec;
                    end
                end
                OP_INIT:
                begin
                    depth_next      = init_count;
                    res.free_pages  = init_count;
                    res.status      = over ? STAT_FULL : STAT_OK;
                    fill_idx_next   = '0;
                    fill_frame_next = start_frame[FRAME_W-1:0];
                    fill_cnt_next   = init_count;
                    if (init_count != '0)
                    begin
                        state_next = BK_FILL;
                    end
                end
                default:
                begin
                    res.status = STAT_OK;
                end
            endcase
        end
    end

    always_comb
    begin
        r2_valid_next = r2_valid_reg;
        r2_res_next   = r2_res_reg;
        if (issue)
        begin
            r2_valid_next = 1'b1;
            r2_res_next   = res;
        end
        else if (r2_adv)
        begin
            r2_valid_next = 1'b0;
        end

        out_valid_next  = out_valid_reg;
        out_grant_next  = out_grant_reg;
        out_status_next = out_status_reg;
        out_free_next   = out_free_reg;
        if (r2_adv)
        begin
            out_valid_next  = 1'b1;
            out_grant_next  = r2_res_reg.grant ? {rd_data_reg, PAGE_SHIFT'(0)} : '0;
            out_status_next = r2_res_reg.status;
            out_free_next   = r2_res_reg.free_pages;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_RUN;
            depth_reg     <= '0;
            r2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            depth_reg     <= depth_next;
            r2_valid_reg  <= r2_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        r2_res_reg     <= r2_res_next;
        out_grant_reg  <= out_grant_next;
        out_status_reg <= out_status_next;
        out_free_reg   <= out_free_next;
        fill_idx_reg   <= fill_idx_next;
        fill_frame_reg <= fill_frame_next;
        fill_cnt_reg   <= fill_cnt_next;
    end

    // Frame stack: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            stack_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= stack_mem[rd_addr];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {(OUT_TDATA_W - ADDRESS_BITS - DEPTH_W)'(0), out_free_reg, out_grant_reg};

endmodule
`default_nettype wire

### hdl/page_frame_free_stack.sv
// Top level of the page frame free stack allocator.
//
// Usage: requests arrive as beats on the slave stream. tuser carries the
// action (free, allocate, initialize) and tdata the page byte address that
// is freed. Every request yields exactly one result beat on the master
// stream: tdata holds the granted page address and the free page count,
// tuser holds the status code. Results leave in request order.
//
// An accepted request beat passes the queue slot, the pipeline stage and
// the output register. Free and allocate requests run at one beat per
// cycle while tready stays high and no initialize fills: a pop reads the
// stack memory through its single registered read port and the result
// register picks the frame up when the pipeline stage advances.
// An initialize walks the range and writes one stack entry per cycle, so it
// blocks the back end until all its pages are pushed (at most 65536); its
// result beat is released right at its start.
// Reset empties the stack and restores the default kernel_end and
// memory_top; no clearing pass is needed. When the receiver holds tready
// low, results wait in the output stage, then in the pipeline stage behind
// it, then the two-entry request queue fills and tready on the slave side
// drops. The user must write configuration only while the block is idle; the block itself does not enforce it.
`default_nettype none
module page_frame_free_stack
    import pfs_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // Configuration write port.
    input  wire logic                   cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [CFG_W-1:0]       cfg_data,
    // Request stream.
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,   // page_address[33:0], zero pad
    input  wire logic [ACT_W-1:0]       s_tuser,   // action[1:0]
    // Result stream.
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [OUT_TDATA_W-1:0]      m_tdata,   // granted_address[33:0], free_pages[50:34], pad
    output logic [STAT_W-1:0]           m_tuser    // status[1:0]
);

    logic [KEND_W-1:0] kernel_end_reg;
    logic [MTOP_W-1:0] memory_top_reg;

    logic push_valid, push_ready;
    op_t  push_op;
    logic pop_valid, pop_ready;
    op_t  pop_op;

    // Configuration registers, written one at a time through the write port.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kernel_end_reg <= KERNEL_END_RST;
            memory_top_reg <= MEMORY_TOP_RST;
        end
        else if (cfg_wr_en)
        begin
            if (cfg_index == REG_KERNEL_END)
            begin
                kernel_end_reg <= cfg_data[KEND_W-1:0];
            end
            if (cfg_index == REG_MEMORY_TOP)
            begin
                memory_top_reg <= cfg_data[MTOP_W-1:0];
            end
        end
    end

    // Request classification: the range check of a free happens here.
    pfs_front u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .kernel_end (kernel_end_reg),
        .memory_top (memory_top_reg),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_op    (push_op)
    );

    // Short queue so the front end keeps taking beats while the back end fills.
    pfs_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_op    (push_op),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_op     (pop_op)
    );

    // Stack execution and result output.
    pfs_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .kernel_end (kernel_end_reg),
        .memory_top (memory_top_reg),
        .op_valid   (pop_valid),
        .op_ready   (pop_ready),
        .op         (pop_op),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

endmodule
`default_nettype wire
